### rtl/odo_pkg.sv
// Shared types, codes and constants of the wheel odometry block.
// Used by odo_arith and differential_drive_odometry; no dependencies.
package odo_pkg;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 152;
   localparam int RSP_USER_W = 1;
   localparam int CSR_DATA_W = 18;

   localparam int CORDIC_STEPS_DEF = 16;

   localparam logic [1:0] ACT_LEFT  = 2'd0;
   localparam logic [1:0] ACT_RIGHT = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_LOAD  = 2'd3;

   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_BASE   = 1'b1;

   localparam logic [15:0] RADIUS_RESET = 16'd4588;
   localparam logic [17:0] BASE_RESET   = 18'd27525;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic [24:0] DIST_K48 = 25'd29475991;

   localparam logic signed [20:0] PI_Q16     = 21'sd205887;
   localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } odo_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } odo_rsp_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat32(input logic neg, input logic [63:0] q);
      logic [31:0] r;
      if (neg) begin
         r = (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end else begin
         r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/odo_arith.sv
// Bit-serial unsigned multiply, restoring divide and integer square root.
// One step per cycle; depends on odo_pkg.
module odo_arith (
   input  logic                clock,
   input  logic                reset,
   input  odo_pkg::odo_cmd_type cmd,
   input  logic [63:0]         opa,
   input  logic [63:0]         opb,
   output odo_pkg::odo_rsp_type rsp
);
   import odo_pkg::*;

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [64:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [63:0] res_ff, res_in;

   logic [63:0] mul_sum;
   logic [64:0] div_rem;
   logic        div_ge;
   logic [64:0] div_sub;
   logic [63:0] sq_rb;
   logic        sq_ge;

   always_comb begin
      mul_sum = acc_ff[63:0] + a_ff;
      div_rem = {acc_ff[63:0], a_ff[63]};
      div_ge  = div_rem >= {1'b0, b_ff};
      div_sub = div_rem - {1'b0, b_ff};
      sq_rb   = a_ff + b_ff;
      sq_ge   = acc_ff[63:0] >= sq_rb;

      busy_in = busy_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = 6'd0;
         if (cmd.op == OP_SQRT) begin
            acc_in = {1'b0, opa};
            a_in   = 64'd0;
            b_in   = 64'h4000_0000_0000_0000;
         end else begin
            acc_in = 65'd0;
            a_in   = opa;
            b_in   = opb;
         end
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               if (b_ff == 64'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = acc_ff[63:0];
               end else begin
                  if (b_ff[0]) begin
                     acc_in = {1'b0, mul_sum};
                  end
                  a_in = {a_ff[62:0], 1'b0};
                  b_in = {1'b0, b_ff[63:1]};
               end
            end
            OP_DIV: begin
               acc_in = div_ge ? div_sub : div_rem;
               a_in   = {a_ff[62:0], div_ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = {a_ff[62:0], div_ge};
               end
            end
            OP_SQRT: begin
               if (b_ff == 64'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = a_ff;
               end else begin
                  if (sq_ge) begin
                     acc_in = {1'b0, acc_ff[63:0] - sq_rb};
                     a_in   = {1'b0, a_ff[63:1]} + b_ff;
                  end else begin
                     a_in = {1'b0, a_ff[63:1]};
                  end
                  b_in = {2'b00, b_ff[63:2]};
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= OP_MUL;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

### rtl/differential_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
// Depends on odo_pkg and odo_arith.
//
// Dead-reckoning integrator for a two-wheel robot in Q.16 fixed point. A wheel
// sample turns rpm and elapsed microseconds into a wheel distance; a pose load
// sets x, y and heading and arms the block; an update tick turns the wheel
// distances into a new pose plus linear and angular velocity, one result per
// tick (ticks before the first pose load give none). All work runs through one
// bit-serial multiply/divide/square-root unit and one shared CORDIC stage, and
// the block takes one item at a time. A pose load and a first wheel sample are
// handled while idle; a later wheel sample runs four multiplies, and a tick's run
// time is set by the one-bit-per-cycle arithmetic unit and two CORDIC passes (in
// the worst case three 64-step divides dominate); a tick whose turn is out of range skips them.
// The result register lets the next item be taken while a result waits.
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // rpm, interval_us, pose_x, pose_y, pose_heading (low bit first)
   input  logic [odo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic [odo_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_position, y_position, heading, linear_velocity, angular_velocity
   output logic [odo_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // step_invalid
   output logic [odo_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [odo_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import odo_pkg::*;

   localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_W_A    = 5'd1;
   localparam logic [4:0] S_W_B    = 5'd2;
   localparam logic [4:0] S_W_C    = 5'd3;
   localparam logic [4:0] S_W_D    = 5'd4;
   localparam logic [4:0] S_W_E    = 5'd5;
   localparam logic [4:0] S_T_PREP = 5'd6;
   localparam logic [4:0] S_T_BAD  = 5'd7;
   localparam logic [4:0] S_T_DIV  = 5'd8;
   localparam logic [4:0] S_T_SQ   = 5'd9;
   localparam logic [4:0] S_T_SQRT = 5'd10;
   localparam logic [4:0] S_T_VEC  = 5'd11;
   localparam logic [4:0] S_T_AVG  = 5'd12;
   localparam logic [4:0] S_T_HALF = 5'd13;
   localparam logic [4:0] S_T_ROT  = 5'd14;
   localparam logic [4:0] S_T_NEG  = 5'd15;
   localparam logic [4:0] S_T_PX   = 5'd16;
   localparam logic [4:0] S_T_PY   = 5'd17;
   localparam logic [4:0] S_T_POS  = 5'd18;
   localparam logic [4:0] S_T_LVM  = 5'd19;
   localparam logic [4:0] S_T_LVD  = 5'd20;
   localparam logic [4:0] S_T_AVM  = 5'd21;
   localparam logic [4:0] S_T_AVD  = 5'd22;
   localparam logic [4:0] S_T_FIN  = 5'd23;

   logic [1:0]         req_action;
   logic [13:0]        req_rpm;
   logic [23:0]        req_iv;
   logic [31:0]        req_px;
   logic [31:0]        req_py;
   logic [18:0]        req_ph;
   logic               req_accept;
   logic [13:0]        rpm_mag;

   logic [4:0]         state_ff, state_in;
   logic               wait_ff, wait_in;
   logic [15:0]        radius_ff, radius_in;
   logic [17:0]        base_ff, base_in;
   logic [31:0]        pos_x_ff, pos_x_in;
   logic [31:0]        pos_y_ff, pos_y_in;
   logic [18:0]        theta_ff, theta_in;
   logic [31:0]        ldist_ff, ldist_in;
   logic [31:0]        rdist_ff, rdist_in;
   logic               lseen_ff, lseen_in;
   logic               rseen_ff, rseen_in;
   logic               loaded_ff, loaded_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic               side_ff, side_in;
   logic               rneg_ff, rneg_in;
   logic [13:0]        arpm_ff, arpm_in;
   logic [23:0]        iv_ff, iv_in;
   logic [63:0]        mag_ff, mag_in;
   logic [63:0]        prod_ff, prod_in;
   logic signed [31:0] cd_ff, cd_in;
   logic [17:0]        ad_ff, ad_in;
   logic               dneg_ff, dneg_in;
   logic [30:0]        am_ff, am_in;
   logic signed [35:0] cx_ff, cx_in;
   logic signed [35:0] cy_ff, cy_in;
   logic signed [35:0] cz_ff, cz_in;
   logic signed [35:0] ang_ff, ang_in;
   logic               neg_ff, neg_in;
   logic [4:0]         step_ff, step_in;
   logic [31:0]        nx_ff, nx_in;
   logic [31:0]        ny_ff, ny_in;
   logic [18:0]        nh_ff, nh_in;
   logic [31:0]        lv_ff, lv_in;
   logic [31:0]        av_ff, av_in;

   odo_cmd_type        u_cmd;
   odo_rsp_type        u_rsp;
   logic [63:0]        u_opa;
   logic [63:0]        u_opb;
   logic               uses_unit;

   logic [32:0]        sum33;
   logic [32:0]        diff33;
   logic [32:0]        ad33;
   logic [17:0]        wb;
   logic signed [35:0] xs;
   logic signed [35:0] ys;
   logic signed [35:0] atan_w;
   logic signed [35:0] avg_raw;
   logic signed [35:0] cz_rnd;
   logic signed [20:0] nh_raw;
   logic signed [20:0] th21;
   logic [31:0]        cd_mag;
   logic [35:0]        cx_mag;
   logic [35:0]        cy_mag;
   logic [35:0]        cz_mag;
   logic               pneg;
   logic [63:0]        sprod;
   logic signed [63:0] rnd;
   logic [31:0]        dist_mag;
   logic               out_free;

   assign req_action = req_tuser[1:0];
   assign req_rpm    = req_tdata[13:0];
   assign req_iv     = req_tdata[37:14];
   assign req_px     = req_tdata[69:38];
   assign req_py     = req_tdata[101:70];
   assign req_ph     = req_tdata[120:102];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rpm_mag    = req_rpm[13] ? (~req_rpm + 14'd1) : req_rpm;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      uses_unit = 1'b1;
      u_cmd.op  = OP_MUL;
      u_opa     = 64'd0;
      u_opb     = 64'd0;
      case (state_ff)
         S_W_A: begin
            u_opa = {48'd0, radius_ff};
            u_opb = {50'd0, arpm_ff};
         end
         S_W_B: begin
            u_opa = mag_ff;
            u_opb = {40'd0, iv_ff};
         end
         S_W_C: begin
            u_opa = {42'd0, mag_ff[53:32]};
            u_opb = {39'd0, DIST_K48};
         end
         S_W_D: begin
            u_opa = {32'd0, mag_ff[31:0]};
            u_opb = {39'd0, DIST_K48};
         end
         S_T_DIV: begin
            u_cmd.op = OP_DIV;
            u_opa    = {16'd0, ad_ff, 30'd0};
            u_opb    = {46'd0, wb};
         end
         S_T_SQ: begin
            u_opa = {33'd0, am_ff};
            u_opb = {33'd0, am_ff};
         end
         S_T_SQRT: begin
            u_cmd.op = OP_SQRT;
            u_opa    = 64'h1000_0000_0000_0000 - mag_ff;
         end
         S_T_PX: begin
            u_opa = {32'd0, cd_mag};
            u_opb = {28'd0, cx_mag};
         end
         S_T_PY: begin
            u_opa = {32'd0, cd_mag};
            u_opb = {28'd0, cy_mag};
         end
         S_T_LVM: begin
            u_opa = {32'd0, cd_mag};
            u_opb = 64'd1000000;
         end
         S_T_AVM: begin
            u_opa = {28'd0, cz_mag};
            u_opb = 64'd1000000;
         end
         S_T_LVD, S_T_AVD: begin
            u_cmd.op = OP_DIV;
            u_opa    = mag_ff;
            u_opb    = {40'd0, iv_ff};
         end
         default: begin
            uses_unit = 1'b0;
         end
      endcase
      u_cmd.start = uses_unit && !wait_ff;
   end

   odo_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (u_cmd),
      .opa   (u_opa),
      .opb   (u_opb),
      .rsp   (u_rsp)
   );

   always_comb begin
      sum33    = {ldist_ff[31], ldist_ff} + {rdist_ff[31], rdist_ff};
      diff33   = {rdist_ff[31], rdist_ff} - {ldist_ff[31], ldist_ff};
      ad33     = diff33[32] ? (~diff33 + 33'd1) : diff33;
      wb       = (base_ff == 18'd0) ? 18'd1 : base_ff;
      xs       = cx_ff >>> step_ff;
      ys       = cy_ff >>> step_ff;
      atan_w   = signed'({4'd0, atan_q30(step_ff)});
      avg_raw  = (cz_ff >>> 1) + (signed'({{17{theta_ff[18]}}, theta_ff}) <<< 14);
      cz_rnd   = (cz_ff + 36'sd8192) >>> 14;
      th21     = signed'({{2{theta_ff[18]}}, theta_ff});
      nh_raw   = cz_rnd[20:0] + th21;
      cd_mag   = cd_ff[31] ? (~cd_ff + 32'd1) : cd_ff;
      cx_mag   = cx_ff[35] ? (~cx_ff + 36'd1) : cx_ff;
      cy_mag   = cy_ff[35] ? (~cy_ff + 36'd1) : cy_ff;
      cz_mag   = cz_ff[35] ? (~cz_ff + 36'd1) : cz_ff;
      pneg     = (state_ff == S_T_PY) ? (cd_ff[31] ^ cy_ff[35]) : (cd_ff[31] ^ cx_ff[35]);
      sprod    = pneg ? (~u_rsp.result + 64'd1) : u_rsp.result;
      rnd      = (signed'(prod_ff) + 64'sd536870912) >>> 30;
      dist_mag = 32'((prod_ff + 64'd32768) >> 16);
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      radius_in    = radius_ff;
      base_in      = base_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      theta_in     = theta_ff;
      ldist_in     = ldist_ff;
      rdist_in     = rdist_ff;
      lseen_in     = lseen_ff;
      rseen_in     = rseen_ff;
      loaded_in    = loaded_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      side_in      = side_ff;
      rneg_in      = rneg_ff;
      arpm_in      = arpm_ff;
      iv_in        = iv_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      cd_in        = cd_ff;
      ad_in        = ad_ff;
      dneg_in      = dneg_ff;
      am_in        = am_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      ang_in       = ang_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nh_in        = nh_ff;
      lv_in        = lv_ff;
      av_in        = av_ff;

      if (csr_we) begin
         case (csr_index)
            REG_RADIUS: radius_in = csr_wdata[15:0];
            REG_BASE:   base_in   = csr_wdata;
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (uses_unit && !wait_ff) begin
         wait_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_LEFT, ACT_RIGHT: begin
                     side_in = (req_action == ACT_RIGHT);
                     rneg_in = req_rpm[13];
                     arpm_in = rpm_mag;
                     iv_in   = req_iv;
                     if (req_action == ACT_RIGHT) begin
                        rseen_in = 1'b1;
                        if (rseen_ff) begin
                           state_in = S_W_A;
                        end
                     end else begin
                        lseen_in = 1'b1;
                        if (lseen_ff) begin
                           state_in = S_W_A;
                        end
                     end
                  end
                  ACT_TICK: begin
                     iv_in = req_iv;
                     if (loaded_ff) begin
                        state_in = S_T_PREP;
                     end
                  end
                  ACT_LOAD: begin
                     pos_x_in  = req_px;
                     pos_y_in  = req_py;
                     theta_in  = req_ph;
                     loaded_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_W_A, S_W_B, S_W_C, S_W_D: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               state_in = state_ff + 5'd1;
               if (state_ff == S_W_C) begin
                  prod_in = u_rsp.result;
               end else if (state_ff == S_W_D) begin
                  prod_in = prod_ff + {32'd0, u_rsp.result[63:32]};
               end else begin
                  mag_in = u_rsp.result;
               end
            end
         end
         S_W_E: begin
            if (side_ff) begin
               rdist_in = rneg_ff ? (~dist_mag + 32'd1) : dist_mag;
            end else begin
               ldist_in = rneg_ff ? (~dist_mag + 32'd1) : dist_mag;
            end
            state_in = S_IDLE;
         end
         S_T_PREP: begin
            cd_in   = signed'(sum33[32:1]);
            ad_in   = ad33[17:0];
            dneg_in = diff33[32];
            state_in = (ad33 > {15'd0, wb}) ? S_T_BAD : S_T_DIV;
         end
         S_T_BAD: begin
            if (out_free) begin
               rsp_data_in  = {5'd0, 32'd0, 32'd0, theta_ff, pos_y_ff, pos_x_ff};
               rsp_user_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_T_DIV: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               am_in    = u_rsp.result[30:0];
               state_in = S_T_SQ;
            end
         end
         S_T_SQ: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               mag_in   = u_rsp.result;
               state_in = S_T_SQRT;
            end
         end
         S_T_SQRT: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               cx_in    = signed'(u_rsp.result[35:0]);
               cy_in    = dneg_ff ? signed'(~{5'd0, am_ff} + 36'd1) : signed'({5'd0, am_ff});
               cz_in    = 36'sd0;
               step_in  = 5'd0;
               state_in = S_T_VEC;
            end
         end
         S_T_VEC: begin
            if (cy_ff > 36'sd0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_w;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_w;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == STEP_LAST) begin
               state_in = S_T_AVG;
            end
         end
         S_T_AVG: begin
            if (avg_raw > PI_Q30) begin
               ang_in = avg_raw - TWO_PI_Q30;
            end else if (avg_raw < -PI_Q30) begin
               ang_in = avg_raw + TWO_PI_Q30;
            end else begin
               ang_in = avg_raw;
            end
            if (nh_raw > PI_Q16) begin
               nh_in = 19'(nh_raw - TWO_PI_Q16);
            end else if (nh_raw < -PI_Q16) begin
               nh_in = 19'(nh_raw + TWO_PI_Q16);
            end else begin
               nh_in = nh_raw[18:0];
            end
            state_in = S_T_HALF;
         end
         S_T_HALF: begin
            if (ang_ff > HALF_PI_Q30) begin
               ang_in = ang_ff - PI_Q30;
               neg_in = 1'b1;
            end else if (ang_ff < -HALF_PI_Q30) begin
               ang_in = ang_ff + PI_Q30;
               neg_in = 1'b1;
            end else begin
               neg_in = 1'b0;
            end
            cx_in    = GAIN_Q30;
            cy_in    = 36'sd0;
            step_in  = 5'd0;
            state_in = S_T_ROT;
         end
         S_T_ROT: begin
            if (ang_ff >= 36'sd0) begin
               cx_in  = cx_ff - ys;
               cy_in  = cy_ff + xs;
               ang_in = ang_ff - atan_w;
            end else begin
               cx_in  = cx_ff + ys;
               cy_in  = cy_ff - xs;
               ang_in = ang_ff + atan_w;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == STEP_LAST) begin
               state_in = S_T_NEG;
            end
         end
         S_T_NEG: begin
            if (neg_ff) begin
               cx_in = -cx_ff;
               cy_in = -cy_ff;
            end
            state_in = S_T_PX;
         end
         S_T_PX: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               prod_in  = sprod;
               state_in = S_T_PY;
            end
         end
         S_T_PY: begin
            if (!wait_ff) begin
               nx_in = pos_x_ff + rnd[31:0];
            end else if (u_rsp.done) begin
               wait_in  = 1'b0;
               prod_in  = sprod;
               state_in = S_T_POS;
            end
         end
         S_T_POS: begin
            ny_in = pos_y_ff + rnd[31:0];
            if (iv_ff == 24'd0) begin
               lv_in    = 32'd0;
               av_in    = 32'd0;
               state_in = S_T_FIN;
            end else begin
               state_in = S_T_LVM;
            end
         end
         S_T_LVM, S_T_AVM: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               mag_in   = u_rsp.result;
               state_in = state_ff + 5'd1;
            end
         end
         S_T_LVD: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               lv_in    = sat32(cd_ff[31], u_rsp.result);
               state_in = S_T_AVM;
            end
         end
         S_T_AVD: begin
            if (wait_ff && u_rsp.done) begin
               wait_in  = 1'b0;
               av_in    = sat32(cz_ff[35], {14'd0, u_rsp.result[63:14]});
               state_in = S_T_FIN;
            end
         end
         S_T_FIN: begin
            if (out_free) begin
               pos_x_in     = nx_ff;
               pos_y_in     = ny_ff;
               theta_in     = nh_ff;
               rsp_data_in  = {5'd0, av_ff, lv_ff, nh_ff, ny_ff, nx_ff};
               rsp_user_in  = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            wait_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         base_ff      <= BASE_RESET;
         pos_x_ff     <= 32'd0;
         pos_y_ff     <= 32'd0;
         theta_ff     <= 19'd0;
         ldist_ff     <= 32'd0;
         rdist_ff     <= 32'd0;
         lseen_ff     <= 1'b0;
         rseen_ff     <= 1'b0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         radius_ff    <= radius_in;
         base_ff      <= base_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         theta_ff     <= theta_in;
         ldist_ff     <= ldist_in;
         rdist_ff     <= rdist_in;
         lseen_ff     <= lseen_in;
         rseen_ff     <= rseen_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      side_ff     <= side_in;
      rneg_ff     <= rneg_in;
      arpm_ff     <= arpm_in;
      iv_ff       <= iv_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      cd_ff       <= cd_in;
      ad_ff       <= ad_in;
      dneg_ff     <= dneg_in;
      am_ff       <= am_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      ang_ff      <= ang_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nh_ff       <= nh_in;
      lv_ff       <= lv_in;
      av_ff       <= av_in;
   end

`ifndef SYNTHESIS
   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      u_rsp.done |-> wait_ff)
      else $error("arithmetic unit finished with no operation pending");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_T_FIN || $past(state_ff) == S_T_BAD))
      else $error("result raised outside a tick completion");

   a_unarmed_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACT_TICK && !loaded_ff) |=> (state_ff == S_IDLE))
      else $error("tick before pose load started work");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the differential-drive wheel odometry block.
// Needs odo_pkg and differential_drive_odometry; a scoreboard class predicts every tick result.
`timescale 1ns / 1ps

module tb_top;
   import odo_pkg::*;

   typedef struct {
      logic [31:0] x_pos;
      logic [31:0] y_pos;
      logic [18:0] head;
      logic [31:0] lin_vel;
      logic [31:0] ang_vel;
      logic        invalid;
   } pose_result_type;

   class odo_scoreboard;
      longint unsigned radius, base;
      longint pos_x, pos_y, left_dist, right_dist;
      logic signed [18:0] theta;
      bit left_seen, right_seen, armed;
      pose_result_type pending_poses[$];
      int fails;
      longint atan_tab[24] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192,
         4096, 2048, 1024, 512, 256, 128};

      function void reset_state();
         radius = 4588;
         base = 27525;
         pos_x = 0;
         pos_y = 0;
         theta = '0;
         left_dist = 0;
         right_dist = 0;
         left_seen = 0;
         right_seen = 0;
         armed = 0;
      endfunction

      function void set_reg(logic idx, logic [17:0] val);
         if (idx == REG_RADIUS) radius = val[15:0];
         else base = val;
      endfunction

      function int pending();
         return pending_poses.size();
      endfunction

      function longint wheel_dist(longint rpm, longint unsigned iv);
         longint unsigned mag, prod, hi, lo, sum;
         longint d;
         mag = (rpm < 0) ? -rpm : rpm;
         prod = radius * mag * iv;
         hi = (prod >> 32) * 64'd29475991;
         lo = (prod & 64'hFFFF_FFFF) * 64'd29475991;
         sum = hi + (lo >> 32);
         d = (sum + 64'd32768) >> 16;
         return (rpm < 0) ? -d : d;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint sat_div(longint num, longint unsigned den);
         longint unsigned mag, q;
         mag = (num < 0) ? -num : num;
         q = mag / den;
         if (num < 0) return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
         return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
      endfunction

      function void integrate(longint unsigned iv);
         pose_result_type r;
         longint cd, diff, a30, x, y, z, xs, ys, ca16, avg, nh, lv, av;
         longint unsigned wb, ad, am;
         bit flip;
         if (!armed) return;
         cd = (left_dist + right_dist) >>> 1;
         diff = right_dist - left_dist;
         wb = (base != 0) ? base : 1;
         ad = (diff < 0) ? -diff : diff;
         if (ad > wb) begin
            r = '{pos_x[31:0], pos_y[31:0], theta, 32'd0, 32'd0, 1'b1};
            pending_poses.push_back(r);
            return;
         end
         am = (ad << 30) / wb;
         a30 = (diff < 0) ? -longint'(am) : longint'(am);
         x = int_sqrt(64'h1000_0000_0000_0000 - am * am);
         y = a30;
         z = 0;
         for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += atan_tab[i];
            end else begin
               x -= ys; y += xs; z -= atan_tab[i];
            end
         end
         ca16 = (z + 8192) >>> 14;
         avg = (z >>> 1) + longint'(theta) * 16384;
         if (avg > 64'sd3373259426) avg -= 64'sd6746518852;
         else if (avg < -64'sd3373259426) avg += 64'sd6746518852;
         flip = 0;
         if (avg > 64'sd1686629713) begin
            avg -= 64'sd3373259426; flip = 1;
         end else if (avg < -64'sd1686629713) begin
            avg += 64'sd3373259426; flip = 1;
         end
         x = 64'sd652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (avg >= 0) begin
               x -= ys; y += xs; avg -= atan_tab[i];
            end else begin
               x += ys; y -= xs; avg += atan_tab[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         pos_x = longint'(signed'(32'(pos_x + ((cd * x + (64'sd1 << 29)) >>> 30))));
         pos_y = longint'(signed'(32'(pos_y + ((cd * y + (64'sd1 << 29)) >>> 30))));
         nh = ca16 + longint'(theta);
         if (nh > 64'sd205887) nh -= 64'sd411775;
         else if (nh < -64'sd205887) nh += 64'sd411775;
         theta = nh[18:0];
         lv = 0;
         av = 0;
         if (iv != 0) begin
            lv = sat_div(cd * 1000000, iv);
            av = sat_div(z * 1000000, iv * 16384);
         end
         r = '{pos_x[31:0], pos_y[31:0], theta, lv[31:0], av[31:0], 1'b0};
         pending_poses.push_back(r);
      endfunction

      function void note(logic [1:0] act, logic signed [13:0] rpm, logic [23:0] iv,
                         logic [31:0] px, logic [31:0] py, logic [18:0] ph);
         case (act)
            ACT_LEFT: begin
               if (left_seen) left_dist = wheel_dist(rpm, iv);
               left_seen = 1;
            end
            ACT_RIGHT: begin
               if (right_seen) right_dist = wheel_dist(rpm, iv);
               right_seen = 1;
            end
            ACT_TICK: integrate(iv);
            default: begin
               pos_x = longint'(signed'(px));
               pos_y = longint'(signed'(py));
               theta = ph;
               armed = 1;
            end
         endcase
      endfunction

      function void check(logic [RSP_DATA_W-1:0] d, logic [RSP_USER_W-1:0] u);
         pose_result_type e;
         if (pending_poses.size() == 0) begin
            $error("unexpected result transfer %h", d);
            fails++;
            return;
         end
         e = pending_poses.pop_front();
         if (d[31:0] !== e.x_pos) begin
            $error("x_position exp %h got %h", e.x_pos, d[31:0]); fails++;
         end
         if (d[63:32] !== e.y_pos) begin
            $error("y_position exp %h got %h", e.y_pos, d[63:32]); fails++;
         end
         if (d[82:64] !== e.head) begin
            $error("heading exp %h got %h", e.head, d[82:64]); fails++;
         end
         if (d[114:83] !== e.lin_vel) begin
            $error("linear_velocity exp %h got %h", e.lin_vel, d[114:83]); fails++;
         end
         if (d[146:115] !== e.ang_vel) begin
            $error("angular_velocity exp %h got %h", e.ang_vel, d[146:115]); fails++;
         end
         if (u[0] !== e.invalid) begin
            $error("step_invalid exp %b got %b", e.invalid, u[0]); fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   odo_scoreboard pose_board = new();
   int burst_left = 0;
   bit long_hold = 0;
   int max_gap = 6;

   differential_drive_odometry dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      int cnt, period, duty, hold;
      cnt = 0;
      period = 1;
      duty = 1;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 0;
            for (hold = 0; hold < 3000; hold++) @(negedge clock);
            long_hold = 0;
         end
         if (cnt % 64 == 0) begin
            period = $urandom_range(1, 9);
            duty = (period == 1) ? 1 : $urandom_range(0, period - 1);
         end
         rsp_tready = ((cnt % period) < duty) || (period == 1);
         cnt++;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) pose_board.check(rsp_tdata, rsp_tuser);

   task automatic write_reg(logic idx, logic [17:0] val);
      @(negedge clock);
      req_tvalid = 0;
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      pose_board.set_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 0;
      while (pose_board.pending() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic send_item(logic [1:0] act, logic [13:0] rpm, logic [23:0] iv,
                            logic [31:0] px, logic [31:0] py, logic [18:0] ph);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tuser = act;
      req_tdata = {7'd0, ph, py, px, iv, rpm};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      pose_board.note(act, rpm, iv, px, py, ph);
   endtask

   task automatic sample(logic [1:0] act, int rpm, int iv);
      send_item(act, rpm[13:0], iv[23:0], $urandom, $urandom, 19'($urandom));
   endtask

   task automatic load(logic [31:0] px, logic [31:0] py, logic [18:0] ph);
      send_item(ACT_LOAD, 14'($urandom), 24'($urandom), px, py, ph);
   endtask

   task automatic random_item();
      logic [13:0] rpm;
      logic [23:0] iv;
      int pick;
      pick = $urandom_range(0, 99);
      rpm = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 600) - 300);
      if ($urandom_range(0, 6) == 0) iv = 24'($urandom);
      else if ($urandom_range(0, 19) == 0) iv = '0;
      else iv = 24'($urandom_range(1, 70000));
      if (pick < 35) send_item(ACT_LEFT, rpm, iv, $urandom, $urandom, 19'($urandom));
      else if (pick < 70) send_item(ACT_RIGHT, rpm, iv, $urandom, $urandom, 19'($urandom));
      else if (pick < 95) send_item(ACT_TICK, rpm, iv, $urandom, $urandom, 19'($urandom));
      else load($urandom, $urandom, 19'($urandom));
   endtask

   initial begin
      logic [17:0] radii[6];
      logic [17:0] bases[6];
      radii = '{18'd4588, 18'd65535, 18'd0, 18'd20000, 18'd1, 18'd4588};
      bases = '{18'd27525, 18'd262143, 18'd1, 18'd0, 18'd50000, 18'd27525};
      pose_board.reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      write_reg(REG_RADIUS, 18'd4588);
      write_reg(REG_BASE, 18'd27525);

      sample(ACT_TICK, 0, 1000);
      sample(ACT_LEFT, 100, 33333);
      sample(ACT_RIGHT, 8191, 33333);
      load(32'd0, 32'd0, 19'd0);
      sample(ACT_LEFT, 0, 24'hFFFFFF);
      sample(ACT_RIGHT, 120, 33333);
      sample(ACT_TICK, 0, 0);
      sample(ACT_TICK, 0, 33333);
      sample(ACT_RIGHT, -8192, 24'hFFFFFF);
      sample(ACT_TICK, 0, 33333);
      sample(ACT_RIGHT, 150, 33333);
      sample(ACT_LEFT, -150, 33333);
      sample(ACT_TICK, 0, 33333);
      load(32'h7FFF_FFFF, 32'h8000_0000, 19'd205887);
      sample(ACT_TICK, 0, 24'hFFFFFF);
      load(32'h8000_0000, 32'h7FFF_FFFF, 19'h40000);
      sample(ACT_TICK, 0, 1);
      load(32'hFFFF_FFFF, 32'd1, 19'h3FFFF);
      sample(ACT_LEFT, 8191, 1);
      sample(ACT_RIGHT, -1, 24'hFFFFFF);
      sample(ACT_TICK, 0, 24'hFFFFFF);
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_RADIUS, radii[ph]);
         write_reg(REG_BASE, bases[ph]);
         max_gap = (ph % 2) ? 0 : 6;
         load($urandom, $urandom, 19'($urandom));
         if (ph == 1) long_hold = 1;
         for (int n = 0; n < 140; n++) random_item();
         drain_results();
      end

      if (pose_board.fails == 0 && pose_board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/odo_pkg.sv
rtl/odo_arith.sv
rtl/differential_drive_odometry.sv
tb/tb_top.sv
